// ===== rtl/glpl_pkg.sv =====
// Shared types and codes for the glyph pen layout block.
package glpl_pkg;

   localparam int FIELD_W = 10;
   localparam int COORD_W = 16;
   localparam int PEN_W   = 32;

   localparam logic [1:0] KIND_GLYPH   = 2'd0;
   localparam logic [1:0] KIND_TAB     = 2'd1;
   localparam logic [1:0] KIND_NEWLINE = 2'd2;

   // Register indexes (byte address / 4)
   localparam logic [2:0] REG_WRAP_ENABLE = 3'd0;
   localparam logic [2:0] REG_MAX_WIDTH   = 3'd1;
   localparam logic [2:0] REG_CLIP_ENABLE = 3'd2;
   localparam logic [2:0] REG_MAX_HEIGHT  = 3'd3;
   localparam logic [2:0] REG_LINE_GAP    = 3'd4;
   localparam logic [2:0] REG_ASCENDER    = 3'd5;

   typedef struct packed {
      logic                      wrap_enable;
      logic signed [COORD_W-1:0] max_width;
      logic                      clip_enable;
      logic signed [COORD_W-1:0] max_height;
      logic [FIELD_W-1:0]        line_pitch;
      logic [FIELD_W-1:0]        ascender;
   } cfg_type;

   typedef struct packed {
      logic                      start_text;
      logic [1:0]                item_kind;
      logic signed [FIELD_W-1:0] glyph_left;
      logic signed [FIELD_W-1:0] glyph_top;
      logic [FIELD_W-1:0]        glyph_width;
      logic [FIELD_W-1:0]        glyph_height;
      logic [FIELD_W-1:0]        pen_step_x;
      logic signed [FIELD_W-1:0] pen_step_y;
   } item_type;

   // Decoded form of an item as the back end consumes it
   typedef struct packed {
      logic                      start_text;
      logic                      is_glyph;
      logic                      is_tab;
      logic                      is_newline;
      logic signed [FIELD_W-1:0] glyph_left;
      logic signed [FIELD_W-1:0] glyph_top;
      logic [FIELD_W-1:0]        glyph_width;
      logic [FIELD_W-1:0]        glyph_height;
      logic [FIELD_W-1:0]        pen_step_x;
      logic signed [FIELD_W-1:0] pen_step_y;
   } op_type;

   typedef struct packed {
      logic                      placed;
      logic                      stopped;
      logic signed [COORD_W-1:0] glyph_x;
      logic signed [COORD_W-1:0] glyph_y;
      logic signed [COORD_W-1:0] box_width;
      logic signed [COORD_W-1:0] box_height;
   } result_type;

endpackage

// ===== rtl/glpl_csr.sv =====
// Configuration register file behind the APB-style port.
module glpl_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [4:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready,
   output glpl_pkg::cfg_type      cfg
);
   import glpl_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_WRAP_ENABLE: cfg_in.wrap_enable = csr_pwdata[0];
            REG_MAX_WIDTH:   cfg_in.max_width   = csr_pwdata[COORD_W-1:0];
            REG_CLIP_ENABLE: cfg_in.clip_enable = csr_pwdata[0];
            REG_MAX_HEIGHT:  cfg_in.max_height  = csr_pwdata[COORD_W-1:0];
            REG_LINE_GAP:    cfg_in.line_pitch  = csr_pwdata[FIELD_W-1:0];
            REG_ASCENDER:    cfg_in.ascender    = csr_pwdata[FIELD_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wrap_enable <= 1'b0;
         cfg_ff.max_width   <= 16'sd32767;
         cfg_ff.clip_enable <= 1'b0;
         cfg_ff.max_height  <= 16'sd32767;
         cfg_ff.line_pitch  <= '0;
         cfg_ff.ascender    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_WRAP_ENABLE: csr_prdata = {31'd0, cfg_ff.wrap_enable};
         REG_MAX_WIDTH:   csr_prdata = {16'd0, cfg_ff.max_width};
         REG_CLIP_ENABLE: csr_prdata = {31'd0, cfg_ff.clip_enable};
         REG_MAX_HEIGHT:  csr_prdata = {16'd0, cfg_ff.max_height};
         REG_LINE_GAP:    csr_prdata = {22'd0, cfg_ff.line_pitch};
         REG_ASCENDER:    csr_prdata = {22'd0, cfg_ff.ascender};
         default:         csr_prdata = 32'd0;
      endcase
   end

endmodule

// ===== rtl/glpl_front.sv =====
// Front end: accepts items, decodes the kind and reduces the advance modulo the tab stop.
module glpl_front #(
   parameter int TAB_STOP = 20,
   parameter int MOD_W    = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  glpl_pkg::item_type     item,
   output logic                   push_valid,
   input  logic                   push_ready,
   output glpl_pkg::op_type       push_op,
   output logic [MOD_W-1:0]       push_adv_mod
);
   import glpl_pkg::*;

   // Reciprocal is exact for every advance below 2^FIELD_W
   localparam int     SHIFT   = FIELD_W + MOD_W;
   localparam int     RECIP_W = SHIFT + 1;
   localparam longint RECIP   = ((64'd1 << SHIFT) + TAB_STOP - 1) / TAB_STOP;
   localparam int     PROD_W  = FIELD_W + RECIP_W;
   localparam int     QT_W    = FIELD_W + MOD_W + 1;

   logic                s1_valid_ff, s1_valid_in;
   op_type              s1_op_ff, s1_op_in;
   logic [FIELD_W-1:0]  s1_quot_ff, s1_quot_in;
   logic [PROD_W-1:0]   prod;
   logic [QT_W-1:0]     quot_t;
   logic [QT_W-1:0]     rem;
   logic                accept;

   assign req_ready  = ~s1_valid_ff | push_ready;
   assign accept     = req_valid & req_ready;
   assign push_valid = s1_valid_ff;
   assign push_op    = s1_op_ff;

   always_comb begin
      prod = PROD_W'(item.pen_step_x) * PROD_W'(RECIP);
      s1_quot_in = prod[SHIFT +: FIELD_W];

      s1_op_in.start_text   = item.start_text;
      s1_op_in.is_glyph     = (item.item_kind == KIND_GLYPH);
      s1_op_in.is_tab       = (item.item_kind == KIND_TAB);
      s1_op_in.is_newline   = (item.item_kind == KIND_NEWLINE);
      s1_op_in.glyph_left   = item.glyph_left;
      s1_op_in.glyph_top    = item.glyph_top;
      s1_op_in.glyph_width  = item.glyph_width;
      s1_op_in.glyph_height = item.glyph_height;
      s1_op_in.pen_step_x   = item.pen_step_x;
      s1_op_in.pen_step_y   = item.pen_step_y;

      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      quot_t       = QT_W'(s1_quot_ff) * QT_W'(TAB_STOP);
      rem          = QT_W'(s1_op_ff.pen_step_x) - quot_t;
      push_adv_mod = rem[MOD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff   <= s1_op_in;
         s1_quot_ff <= s1_quot_in;
      end
   end

endmodule

// ===== rtl/glpl_queue.sv =====
// Four-entry queue between the front end and the back end.
module glpl_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != (PTR_W+1)'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/glpl_back.sv =====
// Back end: pen, box and stop state, one item per cycle unless rsp stalls, with the result register.
module glpl_back #(
   parameter int TAB_STOP = 20,
   parameter int MOD_W    = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  glpl_pkg::cfg_type      cfg,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  glpl_pkg::op_type       op,
   input  logic [MOD_W-1:0]       adv_mod,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output glpl_pkg::result_type   result
);
   import glpl_pkg::*;

   localparam int            SUM_W = MOD_W + 1;
   localparam int            DLT_W = MOD_W + 2;
   // Residue of 2^32, applied whenever the pen wraps around
   localparam int            WRAP_RES = int'((64'd1 << PEN_W) % TAB_STOP);
   localparam logic [SUM_W-1:0] TS   = SUM_W'(TAB_STOP);
   localparam logic [SUM_W-1:0] KRES = SUM_W'(WRAP_RES);

   // pen_mod tracks the unsigned pen x modulo the tab stop
   logic [PEN_W-1:0]   pen_x_ff, pen_x_in;
   logic [PEN_W-1:0]   pen_y_ff, pen_y_in;
   logic [MOD_W-1:0]   pen_mod_ff, pen_mod_in;
   logic [COORD_W-1:0] ext_w_ff, ext_w_in;
   logic [COORD_W-1:0] ext_h_ff, ext_h_in;
   logic               halted_ff, halted_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         result_ff, result_in;

   logic               fire;
   logic [PEN_W-1:0]   px0, py0, px1, py1;
   logic [MOD_W-1:0]   mod0, mod1;
   logic [COORD_W-1:0] ew0, eh0;
   logic               h0, wrap_now, clip_now;
   logic [SUM_W-1:0]   floor_mod;
   logic [DLT_W-1:0]   tab_delta;
   logic [MOD_W-1:0]   tab_dmod;
   logic [PEN_W:0]     sum_x;
   logic [COORD_W-1:0] gx, gy, rw, rh;

   function automatic logic [MOD_W-1:0] mod_add(input logic [MOD_W-1:0] u,
                                                input logic [MOD_W-1:0] d,
                                                input logic carry);
      logic [SUM_W-1:0] t;
      begin
         t = SUM_W'(u) + SUM_W'(d);
         if (t >= TS) begin
            t = t - TS;
         end
         if (carry) begin
            if (t >= KRES) begin
               t = t - KRES;
            end else begin
               t = t + TS - KRES;
            end
         end
         mod_add = t[MOD_W-1:0];
      end
   endfunction

   assign fire      = pop_valid & pop_ready;
   assign pop_ready = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

   always_comb begin
      px0  = op.start_text ? '0 : pen_x_ff;
      py0  = op.start_text ? PEN_W'(cfg.ascender) : pen_y_ff;
      mod0 = op.start_text ? '0 : pen_mod_ff;
      ew0  = op.start_text ? '0 : ext_w_ff;
      eh0  = op.start_text ? '0 : ext_h_ff;
      h0   = op.start_text ? 1'b0 : halted_ff;

      // floor modulo of the signed pen x
      if (!px0[PEN_W-1]) begin
         floor_mod = SUM_W'(mod0);
      end else if (SUM_W'(mod0) >= KRES) begin
         floor_mod = SUM_W'(mod0) - KRES;
      end else begin
         floor_mod = SUM_W'(mod0) + TS - KRES;
      end
      // remainder truncates toward zero, so a negative pen steps further
      if (floor_mod == '0) begin
         tab_delta = DLT_W'(TS);
         tab_dmod  = '0;
      end else begin
         tab_dmod = MOD_W'(TS - floor_mod);
         if (px0[PEN_W-1]) begin
            tab_delta = DLT_W'(TS) + DLT_W'(TS) - DLT_W'(floor_mod);
         end else begin
            tab_delta = DLT_W'(TS) - DLT_W'(floor_mod);
         end
      end

      wrap_now = cfg.wrap_enable &
                 ($signed(px0) > $signed({{(PEN_W-COORD_W){cfg.max_width[COORD_W-1]}},
                                          cfg.max_width}));
      px1  = wrap_now ? '0 : px0;
      py1  = wrap_now ? py0 + PEN_W'(cfg.line_pitch) : py0;
      mod1 = wrap_now ? '0 : mod0;
      clip_now = cfg.clip_enable &
                 ($signed(py1) > $signed({{(PEN_W-COORD_W){cfg.max_height[COORD_W-1]}},
                                          cfg.max_height}));

      gx = px1[COORD_W-1:0] + {{(COORD_W-FIELD_W){op.glyph_left[FIELD_W-1]}}, op.glyph_left};
      gy = py1[COORD_W-1:0] - {{(COORD_W-FIELD_W){op.glyph_top[FIELD_W-1]}}, op.glyph_top};
      rw = gx + COORD_W'(op.glyph_width);
      rh = gy + COORD_W'(op.glyph_height);

      pen_x_in   = px0;
      pen_y_in   = py0;
      pen_mod_in = mod0;
      ext_w_in   = ew0;
      ext_h_in   = eh0;
      halted_in  = h0;
      sum_x      = '0;
      result_in.placed  = 1'b0;
      result_in.glyph_x = '0;
      result_in.glyph_y = '0;

      if (!h0) begin
         if (op.is_tab) begin
            sum_x      = {1'b0, px0} + (PEN_W+1)'(tab_delta);
            pen_x_in   = sum_x[PEN_W-1:0];
            pen_mod_in = mod_add(mod0, tab_dmod, sum_x[PEN_W]);
         end else if (op.is_newline) begin
            pen_x_in   = '0;
            pen_y_in   = py0 + PEN_W'(cfg.line_pitch);
            pen_mod_in = '0;
         end else if (op.is_glyph) begin
            pen_x_in   = px1;
            pen_y_in   = py1;
            pen_mod_in = mod1;
            if (clip_now) begin
               halted_in = 1'b1;
            end else begin
               if ($signed(rw) > $signed(ew0)) begin
                  ext_w_in = rw;
               end
               if ($signed(rh) > $signed(eh0)) begin
                  ext_h_in = rh;
               end
               result_in.placed  = 1'b1;
               result_in.glyph_x = gx;
               result_in.glyph_y = gy;
               sum_x      = {1'b0, px1} + (PEN_W+1)'(op.pen_step_x);
               pen_x_in   = sum_x[PEN_W-1:0];
               pen_mod_in = mod_add(mod1, adv_mod, sum_x[PEN_W]);
               pen_y_in   = py1 - {{(PEN_W-FIELD_W){op.pen_step_y[FIELD_W-1]}}, op.pen_step_y};
            end
         end
      end

      result_in.stopped    = halted_in;
      result_in.box_width  = ext_w_in;
      result_in.box_height = ext_h_in;

      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         pen_mod_ff   <= '0;
         ext_w_ff     <= '0;
         ext_h_ff     <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            pen_x_ff   <= pen_x_in;
            pen_y_ff   <= pen_y_in;
            pen_mod_ff <= pen_mod_in;
            ext_w_ff   <= ext_w_in;
            ext_h_ff   <= ext_h_in;
            halted_ff  <= halted_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result_in;
      end
   end

endmodule

// ===== rtl/glyph_pen_layout_core.sv =====
// Top level of the glyph pen layout block.
//
//   channel   direction  handshake                      payload
//   req_*     in         req_valid / req_ready          one glyph, tab or newline
//   rsp_*     out        rsp_valid / rsp_ready          placement, stop flag, box
//   csr_*     in         APB setup + access, pready=1   six layout registers
//
// One item per cycle sustained while rsp_ready stays high; an accepted req passes
// the decode register, a queue slot and the back-end result register before
// rsp_valid rises. The back end updates pen, box and stop state per item; the tab
// remainder comes from a running residue of pen x, so no divider sits in that loop.
// Synchronous reset clears the pen (y is the ascender at the next run start).
// A stalled rsp side holds six transactions (result register, four-entry queue,
// decode register) before req_ready drops.
module glyph_pen_layout_core #(
   parameter int TAB_STOP = 20
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_start_text,
   input  logic [1:0]              req_item_kind,
   input  logic signed [9:0]       req_glyph_left,
   input  logic signed [9:0]       req_glyph_top,
   input  logic [9:0]              req_glyph_width,
   input  logic [9:0]              req_glyph_height,
   input  logic [9:0]              req_pen_step_x,
   input  logic signed [9:0]       req_pen_step_y,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_placed,
   output logic                    rsp_stopped,
   output logic signed [15:0]      rsp_glyph_x,
   output logic signed [15:0]      rsp_glyph_y,
   output logic signed [15:0]      rsp_box_width,
   output logic signed [15:0]      rsp_box_height,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [4:0]              csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   import glpl_pkg::*;

   localparam int MOD_W   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
   localparam int ENTRY_W = $bits(op_type) + MOD_W;

   cfg_type              cfg;
   item_type             item;
   op_type               push_op, pop_op;
   logic [MOD_W-1:0]     push_adv_mod, pop_adv_mod;
   logic                 push_valid, push_ready, pop_valid, pop_ready;
   logic [ENTRY_W-1:0]   pop_data;
   result_type           result;

   assign item.start_text   = req_start_text;
   assign item.item_kind    = req_item_kind;
   assign item.glyph_left   = req_glyph_left;
   assign item.glyph_top    = req_glyph_top;
   assign item.glyph_width  = req_glyph_width;
   assign item.glyph_height = req_glyph_height;
   assign item.pen_step_x   = req_pen_step_x;
   assign item.pen_step_y   = req_pen_step_y;

   glpl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   glpl_front #(
      .TAB_STOP (TAB_STOP),
      .MOD_W    (MOD_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .item         (item),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_op      (push_op),
      .push_adv_mod (push_adv_mod)
   );

   glpl_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_op, push_adv_mod}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_op      = pop_data[ENTRY_W-1:MOD_W];
   assign pop_adv_mod = pop_data[MOD_W-1:0];

   glpl_back #(
      .TAB_STOP (TAB_STOP),
      .MOD_W    (MOD_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .op        (pop_op),
      .adv_mod   (pop_adv_mod),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .result    (result)
   );

   assign rsp_placed     = result.placed;
   assign rsp_stopped    = result.stopped;
   assign rsp_glyph_x    = result.glyph_x;
   assign rsp_glyph_y    = result.glyph_y;
   assign rsp_box_width  = result.box_width;
   assign rsp_box_height = result.box_height;

endmodule
